// ===== rtl/core/lpbe_pkg.sv =====
// ----------------------------------------------------------------------------
// LED pixel buffer engine package
// Shared widths, request and status codes, and the command record that the
// front end hands to the back end through the command queue.
// ----------------------------------------------------------------------------
package lpbe_pkg;

    localparam int LEN_W              = 11;
    localparam int POS_W              = 10;
    localparam int CNT_W              = 11;
    localparam int CHAN_W             = 8;
    localparam int COLOR_W            = 3 * CHAN_W;
    localparam int REQ_W              = 3;
    localparam int MAX_PIXELS_DEFAULT = 1024;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [LEN_W-1:0] ACTIVE_LENGTH_RESET = 11'd1024;

    localparam logic [REQ_W-1:0] REQ_PUT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_GET   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FILL  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ROT_R = 3'd3;
    localparam logic [REQ_W-1:0] REQ_ROT_L = 3'd4;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_CLAMP = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_PUT  = 3'd1,
        OP_GET  = 3'd2,
        OP_FILL = 3'd3,
        OP_ROT  = 3'd4
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [LEN_W-1:0]   start;
        logic [LEN_W-1:0]   len;
        logic [CNT_W-1:0]   count;
        logic               left;
        logic [COLOR_W-1:0] color;
        status_t            status;
    } cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        status_t            status;
    } result_t;

endpackage

// ===== rtl/core/lpbe_front.sv =====
// ----------------------------------------------------------------------------
// LED pixel buffer front end
// Holds the active length register, checks each request against it and
// turns it into a command for the back end.
// ----------------------------------------------------------------------------
module lpbe_front #(
    parameter int MAX_PIXELS = lpbe_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [lpbe_pkg::LEN_W-1:0] cfg_wr_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [55:0]                s_axis_tdata,
    input  logic [lpbe_pkg::REQ_W-1:0] s_axis_tuser,
    input  logic                       init_done,
    input  logic                       q_ready,
    output logic                       q_push,
    output lpbe_pkg::cmd_t             q_cmd
);
    import lpbe_pkg::*;

    logic [LEN_W-1:0] active_length_reg;
    logic [LEN_W-1:0] used_len;
    logic [LEN_W-1:0] pos_ext;
    logic [LEN_W-1:0] range_end;
    logic [CNT_W-1:0] count;
    logic [LEN_W:0]   fill_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_length_reg <= ACTIVE_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            active_length_reg <= cfg_wr_data;
        end
    end

    assign used_len  = ({21'd0, active_length_reg} < MAX_PIXELS) ? active_length_reg
                                                                  : LEN_W'(MAX_PIXELS);
    assign pos_ext   = {1'b0, s_axis_tdata[9:0]};
    assign range_end = s_axis_tdata[20:10];
    assign count     = s_axis_tdata[31:21];
    assign fill_end  = {1'b0, pos_ext} + {1'b0, count};

    assign s_axis_tready = q_ready && init_done;
    assign q_push        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        q_cmd        = '0;
        q_cmd.op     = OP_NONE;
        q_cmd.status = STATUS_DONE;
        q_cmd.start  = pos_ext;
        q_cmd.count  = count;
        q_cmd.color  = {s_axis_tdata[39:32], s_axis_tdata[47:40], s_axis_tdata[55:48]};
        q_cmd.left   = (s_axis_tuser == REQ_ROT_L);
        unique case (s_axis_tuser) inside
            REQ_PUT, REQ_GET: begin
                if (pos_ext < used_len) begin
                    q_cmd.op = (s_axis_tuser == REQ_PUT) ? OP_PUT : OP_GET;
                end else begin
                    q_cmd.status = STATUS_RANGE;
                end
            end
            REQ_FILL: begin
                if (pos_ext >= used_len) begin
                    q_cmd.status = STATUS_RANGE;
                end else if (fill_end > {1'b0, used_len}) begin
                    q_cmd.op     = OP_FILL;
                    q_cmd.len    = used_len - pos_ext;
                    q_cmd.status = STATUS_CLAMP;
                end else if (count != '0) begin
                    q_cmd.op  = OP_FILL;
                    q_cmd.len = count;
                end
            end
            REQ_ROT_R, REQ_ROT_L: begin
                if (pos_ext >= range_end || range_end > used_len) begin
                    q_cmd.status = STATUS_RANGE;
                end else begin
                    q_cmd.op  = OP_ROT;
                    q_cmd.len = range_end - pos_ext;
                end
            end
            default: begin
                q_cmd.status = STATUS_RANGE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lpbe_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// LED pixel buffer command queue
// Short first-in first-out queue of checked commands between the front end
// and the back end.
// ----------------------------------------------------------------------------
module lpbe_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lpbe_pkg::cmd_t push_cmd,
    output logic           ready,
    input  logic           pop,
    output logic           head_valid,
    output lpbe_pkg::cmd_t head_cmd
);
    import lpbe_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;

    assign ready      = (fill_reg != (PTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/lpbe_mod_unit.sv =====
// ----------------------------------------------------------------------------
// LED pixel buffer modulo unit
// Restoring division that yields the remainder of the rotate count by the
// range length, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpbe_mod_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lpbe_pkg::CNT_W-1:0] dividend,
    input  logic [lpbe_pkg::LEN_W-1:0] divisor,
    output logic                       done,
    output logic [lpbe_pkg::LEN_W-1:0] remainder
);
    import lpbe_pkg::*;

    localparam int STEP_W = $clog2(CNT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  dvd_reg;
    logic [LEN_W-1:0]  div_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W:0]    trial;
    logic [LEN_W:0]    diff;

    assign trial     = {rem_reg, dvd_reg[CNT_W-1]};
    assign diff      = trial - {1'b0, div_reg};
    assign done      = done_reg;
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[CNT_W-2:0], 1'b0};
            rem_reg <= (trial >= {1'b0, div_reg}) ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(CNT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/lpbe_back.sv =====
// ----------------------------------------------------------------------------
// LED pixel buffer back end
// Owns the pixel store and the rotate scratch memory, runs the clearing
// pass, executes commands from the queue and holds the result register.
// ----------------------------------------------------------------------------
module lpbe_back #(
    parameter int MAX_PIXELS = lpbe_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  lpbe_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    output logic              init_done,
    output logic              res_valid,
    input  logic              res_ready,
    output lpbe_pkg::result_t res
);
    import lpbe_pkg::*;

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    typedef enum logic [7:0] {
        BK_CLEAR  = 8'b0000_0001,
        BK_IDLE   = 8'b0000_0010,
        BK_FILL   = 8'b0000_0100,
        BK_MOD    = 8'b0000_1000,
        BK_COPY   = 8'b0001_0000,
        BK_TURN   = 8'b0010_0000,
        BK_BACK   = 8'b0100_0000,
        BK_FINISH = 8'b1000_0000
    } bk_state_t;

    logic [COLOR_W-1:0] store_mem   [MAX_PIXELS];
    logic [COLOR_W-1:0] scratch_mem [MAX_PIXELS];
    logic [COLOR_W-1:0] store_rd_reg;
    logic [COLOR_W-1:0] scratch_rd_reg;

    bk_state_t        state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] j_reg, j_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_to_store_reg, pend_to_store_next;
    logic [AW-1:0]    pend_addr_reg, pend_addr_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_res_reg, out_res_next;

    logic               st_we, st_re, sc_we, sc_re;
    logic [AW-1:0]      st_wa, st_ra, sc_ra;
    logic [COLOR_W-1:0] st_wd;
    logic [LEN_W-1:0]   run_addr;
    logic [LEN_W-1:0]   last_idx;
    logic [LEN_W-1:0]   shift_k;
    logic               mod_start, mod_done;
    logic [LEN_W-1:0]   mod_rem;

    lpbe_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (q_cmd.count),
        .divisor   (q_cmd.len),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign run_addr  = cmd_reg.start + idx_reg;
    assign last_idx  = cmd_reg.len - 1'b1;
    assign shift_k   = (cmd_reg.left && mod_rem != '0) ? cmd_reg.len - mod_rem : mod_rem;
    assign sc_we     = pend_valid_reg && !pend_to_store_reg;
    assign init_done = (state_reg != BK_CLEAR);
    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

    always_comb begin
        state_next         = state_reg;
        cmd_next           = cmd_reg;
        idx_next           = idx_reg;
        j_next             = j_reg;
        pend_valid_next    = 1'b0;
        pend_to_store_next = pend_to_store_reg;
        pend_addr_next     = pend_addr_reg;
        clr_addr_next      = clr_addr_reg;
        out_valid_next     = out_valid_reg;
        out_res_next       = out_res_reg;
        q_pop              = 1'b0;
        mod_start          = 1'b0;
        st_we              = 1'b0;
        st_wa              = '0;
        st_wd              = '0;
        st_re              = 1'b0;
        st_ra              = '0;
        sc_re              = 1'b0;
        sc_ra              = '0;

        if (pend_valid_reg && pend_to_store_reg) begin
            st_we = 1'b1;
            st_wa = pend_addr_reg;
            st_wd = scratch_rd_reg;
        end
        if (out_valid_reg && res_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_CLEAR: begin
                st_we         = 1'b1;
                st_wa         = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(MAX_PIXELS - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    idx_next = '0;
                    case (q_cmd.op)
                        OP_PUT: begin
                            st_we      = 1'b1;
                            st_wa      = AW'(q_cmd.start);
                            st_wd      = q_cmd.color;
                            state_next = BK_FINISH;
                        end
                        OP_GET: begin
                            st_re      = 1'b1;
                            st_ra      = AW'(q_cmd.start);
                            state_next = BK_FINISH;
                        end
                        OP_FILL: begin
                            state_next = BK_FILL;
                        end
                        OP_ROT: begin
                            mod_start  = 1'b1;
                            state_next = BK_MOD;
                        end
                        default: begin
                            state_next = BK_FINISH;
                        end
                    endcase
                end
            end
            BK_FILL: begin
                st_we    = 1'b1;
                st_wa    = AW'(run_addr);
                st_wd    = cmd_reg.color;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == last_idx) begin
                    state_next = BK_FINISH;
                end
            end
            BK_MOD: begin
                if (mod_done) begin
                    j_next     = shift_k;
                    state_next = (shift_k == '0) ? BK_FINISH : BK_COPY;
                end
            end
            BK_COPY: begin
                st_re              = 1'b1;
                st_ra              = AW'(run_addr);
                pend_valid_next    = 1'b1;
                pend_to_store_next = 1'b0;
                pend_addr_next     = AW'(j_reg);
                j_next             = (j_reg == last_idx) ? '0 : j_reg + 1'b1;
                idx_next           = idx_reg + 1'b1;
                if (idx_reg == last_idx) begin
                    idx_next   = '0;
                    state_next = BK_TURN;
                end
            end
            BK_TURN: begin
                state_next = BK_BACK;
            end
            BK_BACK: begin
                sc_re              = 1'b1;
                sc_ra              = AW'(idx_reg);
                pend_valid_next    = 1'b1;
                pend_to_store_next = 1'b1;
                pend_addr_next     = AW'(run_addr);
                idx_next           = idx_reg + 1'b1;
                if (idx_reg == last_idx) begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH: begin
                if (!out_valid_reg || res_ready) begin
                    out_valid_next      = 1'b1;
                    out_res_next.color  = (cmd_reg.op == OP_GET) ? store_rd_reg : '0;
                    out_res_next.status = cmd_reg.status;
                    state_next          = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[st_wa] <= st_wd;
        end
        if (st_re) begin
            store_rd_reg <= store_mem[st_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (sc_we) begin
            scratch_mem[pend_addr_reg] <= store_rd_reg;
        end
        if (sc_re) begin
            scratch_rd_reg <= scratch_mem[sc_ra];
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg           <= cmd_next;
        idx_reg           <= idx_next;
        j_reg             <= j_next;
        pend_to_store_reg <= pend_to_store_next;
        pend_addr_reg     <= pend_addr_next;
        out_res_reg       <= out_res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_CLEAR;
            clr_addr_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/led_pixel_buffer_engine.sv =====
// ----------------------------------------------------------------------------
// LED pixel buffer engine
// Pixel store for an LED strip with put, get, fill and range rotate requests.
//
//   Channel      Direction  Contents
//   s_axis       in         one request per beat, request type in tuser
//   m_axis       out        one result per request: colour read and status
//   cfg_wr       in         active length register write
//
// Put, get and rejected requests go from idle straight to the finish state;
// a fill walks its range, and a rotate runs the bit-serial modulo unit, copies
// the range to scratch at the shifted places and writes it back, skipping the
// copy on a zero net shift. After reset a clearing pass over all MAX_PIXELS
// entries blackens the store and no beat is accepted meanwhile. A two-entry
// command queue and the result register let either side stall on its own.
// ----------------------------------------------------------------------------
module led_pixel_buffer_engine #(
    parameter int MAX_PIXELS = lpbe_pkg::MAX_PIXELS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // position[9:0], range_end[20:10], count[31:21], color_red[39:32],
    // color_green[47:40], color_blue[55:48]
    input  logic [55:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_red[7:0], read_green[15:8], read_blue[23:16], status[25:24], zero above
    output logic [31:0] m_axis_tdata
);
    import lpbe_pkg::*;

    logic    q_push, q_ready, q_pop, q_valid, init_done;
    cmd_t    push_cmd, head_cmd;
    result_t res;

    lpbe_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .init_done     (init_done),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    lpbe_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .ready      (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    lpbe_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .init_done (init_done),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {6'd0, res.status, res.color[7:0], res.color[15:8], res.color[23:16]};

endmodule
